@@ design/fapdl_pkg.sv @@
package fapdl_pkg;

	// Field widths
	localparam int unsigned MODE_W   = 2;
	localparam int unsigned RAW_W    = 16;
	localparam int unsigned DRIVE_W  = 8;
	localparam int unsigned POS_W    = 48;
	localparam int unsigned TURN_W   = 32;
	localparam int unsigned LIMIT_W  = 31;
	localparam int unsigned SPEED_W  = 7;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = LIMIT_W;

	// Default parameter values
	localparam int unsigned WRAP_HALF_DEF    = 16384;
	localparam int unsigned ENCODER_SPAN_DEF = 32768;

	typedef enum logic [MODE_W-1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_BUTTON = 2'd1,
		MODE_TICK   = 2'd2
	} mode_t;

	// Register indices on the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ENTER_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_EXIT_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_EXIT_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_ENTER_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SPEED    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED      = 3'd6;

	// Register reset values
	localparam logic [LIMIT_W-1:0] SLOW_ENTER_LOW_RST  = 31'd8000;
	localparam logic [LIMIT_W-1:0] SLOW_EXIT_LOW_RST   = 31'd12000;
	localparam logic [LIMIT_W-1:0] SLOW_EXIT_HIGH_RST  = 31'd44000;
	localparam logic [LIMIT_W-1:0] SLOW_ENTER_HIGH_RST = 31'd48000;
	localparam logic [LIMIT_W-1:0] TRAVEL_LIMIT_RST    = 31'd56000;
	localparam logic [SPEED_W-1:0] NORMAL_SPEED_RST    = 7'd50;
	localparam logic [SPEED_W-1:0] SLOW_SPEED_RST      = 7'd30;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;
	localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 8'sd100;

endpackage

@@ design/fapdl_if.sv @@
interface fapdl_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [fapdl_pkg::MODE_W-1:0]           mode;
	logic signed [fapdl_pkg::RAW_W-1:0]     encoder_raw;
	logic                                   switch_a;
	logic                                   switch_b;
	logic                                   raise_button;
	logic                                   lower_button;

	modport source (output valid, mode, encoder_raw, switch_a, switch_b,
		raise_button, lower_button, input ready);
	modport sink (input valid, mode, encoder_raw, switch_a, switch_b,
		raise_button, lower_button, output ready);
endinterface

interface fapdl_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [fapdl_pkg::DRIVE_W-1:0]   drive;
	logic signed [fapdl_pkg::POS_W-1:0]     position;
	logic                                   slow_zone;
	logic signed [fapdl_pkg::TURN_W-1:0]    turns;

	modport source (output valid, drive, position, slow_zone, turns, input ready);
	modport sink (input valid, drive, position, slow_zone, turns, output ready);
endinterface

interface fapdl_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [fapdl_pkg::CFG_IDX_W-1:0]        index;
	logic [fapdl_pkg::CFG_DATA_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/fork_axis_position_and_drive_limit.sv @@
// Channel   | Role   | Payload
// ----------+--------+------------------------------------------------------
// item_in   | sink   | mode, encoder_raw, switch_a, switch_b, raise/lower_button
// result_out| source | drive, position, slow_zone, turns
// cfg       | sink   | index (register number), data
//
// One item per cycle sustained while result_out is ready. An accepted item is
// held in the input stage and, when it advances, updates the axis state and
// lands in the result register, which offers its result. The single-pass
// update loop through the state registers sets the rate. Reset clears the
// valid flags and axis state and loads register defaults. Output stall backs
// up through the result register to item_in.ready; cfg.ready is always high.
module fork_axis_position_and_drive_limit #(
	parameter int unsigned WRAP_HALF    = fapdl_pkg::WRAP_HALF_DEF,
	parameter int unsigned ENCODER_SPAN = fapdl_pkg::ENCODER_SPAN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fapdl_in_if.sink    item_in,
	fapdl_out_if.source result_out,
	fapdl_cfg_if.sink   cfg
);

	localparam int unsigned POS_W  = fapdl_pkg::POS_W;
	localparam int unsigned TURN_W = fapdl_pkg::TURN_W;
	localparam int unsigned RAW_W  = fapdl_pkg::RAW_W;
	localparam int unsigned LIM_W  = fapdl_pkg::LIMIT_W;
	localparam int unsigned SPD_W  = fapdl_pkg::SPEED_W;
	localparam int unsigned DRV_W  = fapdl_pkg::DRIVE_W;

	localparam logic [POS_W-1:0] SPAN48 = POS_W'(ENCODER_SPAN);
	// turn * span at the two ends of the 32-bit turn range, modulo 2^48
	localparam logic [63:0] BASE_MAX_W = 64'd2147483647 * 64'(ENCODER_SPAN);
	localparam logic [63:0] BASE_MIN_W = 64'd0 - (64'd2147483648 * 64'(ENCODER_SPAN));
	localparam logic [POS_W-1:0] BASE_MAX = BASE_MAX_W[POS_W-1:0];
	localparam logic [POS_W-1:0] BASE_MIN = BASE_MIN_W[POS_W-1:0];
	localparam logic signed [RAW_W+1:0] HALF_P = (RAW_W+2)'(WRAP_HALF);
	localparam logic signed [RAW_W+1:0] HALF_N = -HALF_P;
	localparam logic [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
	localparam logic [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
	localparam logic [TURN_W-1:0] TURN_ONE = {{(TURN_W-1){1'b0}}, 1'b1};

	// configuration registers
	logic [LIM_W-1:0] enter_low_q, exit_low_q, exit_high_q, enter_high_q, travel_q;
	logic [SPD_W-1:0] normal_spd_q, slow_spd_q;

	// input stage
	logic                    valid_s1;
	logic [1:0]              mode_s1;
	logic signed [RAW_W-1:0] raw_s1;
	logic                    sw_a_s1, sw_b_s1, raise_s1, lower_s1;

	// axis state
	logic                    seeded_q;
	logic signed [RAW_W-1:0] prev_raw_q;
	logic [TURN_W-1:0]       turn_q;
	logic [POS_W-1:0]        base_q;      // sign-extended turn_q * span
	logic [POS_W-1:0]        offset_q;
	logic [POS_W-1:0]        axis_q;
	logic                    lat_a_q, lat_b_q, slow_q;
	logic signed [DRV_W-1:0] drive_q;

	// result register
	logic                    out_valid_q;
	logic signed [DRV_W-1:0] drive_out_q;
	logic [POS_W-1:0]        pos_out_q;
	logic                    slow_out_q;
	logic [TURN_W-1:0]       turns_out_q;

	logic advance;

	// next-state values
	logic                    seeded_nx;
	logic signed [RAW_W-1:0] prev_raw_nx;
	logic [TURN_W-1:0]       turn_nx;
	logic [POS_W-1:0]        base_nx, offset_nx, axis_nx;
	logic                    lat_a_nx, lat_b_nx, slow_nx;
	logic signed [DRV_W-1:0] drive_nx;

	logic signed [RAW_W-1:0] prev_eff;
	logic signed [RAW_W:0]   diff;
	logic [POS_W-1:0]        total;
	logic signed [POS_W-1:0] pos_s;
	logic                    in_enter, in_exit, at_travel;
	logic [SPD_W-1:0]        spd_sel, spd;
	logic signed [DRV_W-1:0] spd_pos, spd_neg;

	assign advance       = valid_s1 && (!out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	assign result_out.valid     = out_valid_q;
	assign result_out.drive     = drive_out_q;
	assign result_out.position  = pos_out_q;
	assign result_out.slow_zone = slow_out_q;
	assign result_out.turns     = turns_out_q;

	// unwrap path
	assign prev_eff = seeded_q ? prev_raw_q : raw_s1;
	assign diff     = {raw_s1[RAW_W-1], raw_s1} - {prev_eff[RAW_W-1], prev_eff};

	// drive path
	assign pos_s     = $signed(axis_q);
	assign in_enter  = (pos_s <= $signed({{(POS_W-LIM_W){1'b0}}, enter_low_q}))
		|| (pos_s >= $signed({{(POS_W-LIM_W){1'b0}}, enter_high_q}));
	assign in_exit   = (pos_s >= $signed({{(POS_W-LIM_W){1'b0}}, exit_low_q}))
		&& (pos_s <= $signed({{(POS_W-LIM_W){1'b0}}, exit_high_q}));
	assign at_travel = pos_s >= $signed({{(POS_W-LIM_W){1'b0}}, travel_q});

	always_comb begin
		seeded_nx   = seeded_q;
		prev_raw_nx = prev_raw_q;
		turn_nx     = turn_q;
		base_nx     = base_q;
		offset_nx   = offset_q;
		axis_nx     = axis_q;
		lat_a_nx    = lat_a_q;
		lat_b_nx    = lat_b_q;
		slow_nx     = slow_q;
		drive_nx    = drive_q;
		total       = '0;
		spd_sel     = '0;
		spd         = '0;
		spd_pos     = '0;
		spd_neg     = '0;
		case (mode_s1)
			fapdl_pkg::MODE_SAMPLE: begin
				lat_a_nx    = sw_a_s1;
				lat_b_nx    = sw_b_s1;
				seeded_nx   = 1'b1;
				prev_raw_nx = raw_s1;
				if ($signed({diff[RAW_W], diff}) > HALF_P) begin
					turn_nx = turn_q - TURN_ONE;
					base_nx = (turn_q == TURN_MIN) ? BASE_MAX : base_q - SPAN48;
				end else if ($signed({diff[RAW_W], diff}) < HALF_N) begin
					turn_nx = turn_q + TURN_ONE;
					base_nx = (turn_q == TURN_MAX) ? BASE_MIN : base_q + SPAN48;
				end
				total     = base_nx + {{(POS_W-RAW_W){raw_s1[RAW_W-1]}}, raw_s1};
				offset_nx = sw_a_s1 ? total : offset_q;
				// -(total - offset)
				axis_nx   = offset_nx - total;
			end
			fapdl_pkg::MODE_BUTTON: begin
				if (in_enter) begin
					slow_nx = 1'b1;
				end else if (in_exit) begin
					slow_nx = 1'b0;
				end
				spd_sel = slow_nx ? slow_spd_q : normal_spd_q;
				spd     = (spd_sel > fapdl_pkg::SPEED_MAX) ? fapdl_pkg::SPEED_MAX : spd_sel;
				spd_pos = $signed({1'b0, spd});
				spd_neg = -spd_pos;
				if (lat_a_q) begin
					drive_nx = lower_s1 ? spd_neg : '0;
				end else if (lat_b_q || at_travel) begin
					drive_nx = raise_s1 ? spd_pos : '0;
				end else if (raise_s1) begin
					drive_nx = spd_pos;
				end else if (lower_s1) begin
					drive_nx = spd_neg;
				end else begin
					drive_nx = '0;
				end
			end
			fapdl_pkg::MODE_TICK: begin
				if (lat_a_q && drive_q > 0) begin
					drive_nx = '0;
				end
				if (lat_b_q && drive_q < 0) begin
					drive_nx = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_low_q  <= fapdl_pkg::SLOW_ENTER_LOW_RST;
			exit_low_q   <= fapdl_pkg::SLOW_EXIT_LOW_RST;
			exit_high_q  <= fapdl_pkg::SLOW_EXIT_HIGH_RST;
			enter_high_q <= fapdl_pkg::SLOW_ENTER_HIGH_RST;
			travel_q     <= fapdl_pkg::TRAVEL_LIMIT_RST;
			normal_spd_q <= fapdl_pkg::NORMAL_SPEED_RST;
			slow_spd_q   <= fapdl_pkg::SLOW_SPEED_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				fapdl_pkg::CFG_SLOW_ENTER_LOW:  enter_low_q  <= cfg.data;
				fapdl_pkg::CFG_SLOW_EXIT_LOW:   exit_low_q   <= cfg.data;
				fapdl_pkg::CFG_SLOW_EXIT_HIGH:  exit_high_q  <= cfg.data;
				fapdl_pkg::CFG_SLOW_ENTER_HIGH: enter_high_q <= cfg.data;
				fapdl_pkg::CFG_TRAVEL_LIMIT:    travel_q     <= cfg.data;
				fapdl_pkg::CFG_NORMAL_SPEED:    normal_spd_q <= cfg.data[SPD_W-1:0];
				fapdl_pkg::CFG_SLOW_SPEED:      slow_spd_q   <= cfg.data[SPD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			mode_s1  <= item_in.mode;
			raw_s1   <= item_in.encoder_raw;
			sw_a_s1  <= item_in.switch_a;
			sw_b_s1  <= item_in.switch_b;
			raise_s1 <= item_in.raise_button;
			lower_s1 <= item_in.lower_button;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q   <= 1'b0;
			prev_raw_q <= '0;
			turn_q     <= '0;
			base_q     <= '0;
			offset_q   <= '0;
			axis_q     <= '0;
			lat_a_q    <= 1'b0;
			lat_b_q    <= 1'b0;
			slow_q     <= 1'b0;
			drive_q    <= '0;
		end else if (advance) begin
			seeded_q   <= seeded_nx;
			prev_raw_q <= prev_raw_nx;
			turn_q     <= turn_nx;
			base_q     <= base_nx;
			offset_q   <= offset_nx;
			axis_q     <= axis_nx;
			lat_a_q    <= lat_a_nx;
			lat_b_q    <= lat_b_nx;
			slow_q     <= slow_nx;
			drive_q    <= drive_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_out_q <= drive_nx;
			pos_out_q   <= axis_nx;
			slow_out_q  <= slow_nx;
			turns_out_q <= turn_nx;
		end
	end

endmodule

@@ design/fapdl_checker.sv @@
module fapdl_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [fapdl_pkg::DRIVE_W-1:0] drive,
	input logic signed [fapdl_pkg::POS_W-1:0]   position,
	input logic                                 slow_zone,
	input logic signed [fapdl_pkg::TURN_W-1:0]  turns
);

	logic [1:0]                          pending_q;
	logic                                seen_q;
	logic [fapdl_pkg::TURN_W-1:0]        last_turns_q;
	logic                                in_tx, out_tx;
	logic [fapdl_pkg::TURN_W-1:0]        turn_step;

	assign in_tx     = in_valid && in_ready;
	assign out_tx    = out_valid && out_ready;
	assign turn_step = turns - last_turns_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			seen_q       <= 1'b0;
			last_turns_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_tx} - {1'b0, out_tx};
			if (out_tx) begin
				seen_q       <= 1'b1;
				last_turns_q <= turns;
			end
		end
	end

	// at most the input stage and the result register hold transactions
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 2'd2)
		else $error("more transactions in flight than stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result offered with no transaction outstanding");

	a_turn_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_tx && seen_q |-> turn_step == '0 || turn_step == 32'd1 || turn_step == '1)
		else $error("turn count moved by more than one between results");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive <= fapdl_pkg::DRIVE_LIMIT && drive >= -fapdl_pkg::DRIVE_LIMIT)
		else $error("drive beyond speed limit");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(position)
			&& $stable(slow_zone) && $stable(turns))
		else $error("stalled result changed");

endmodule

bind fork_axis_position_and_drive_limit fapdl_checker u_fapdl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item_in.valid),
	.in_ready  (item_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.drive     (result_out.drive),
	.position  (result_out.position),
	.slow_zone (result_out.slow_zone),
	.turns     (result_out.turns)
);

@@ sim/fork_axis_report_check.sv @@
`timescale 1ns / 100ps

module fork_axis_report_check (
	input  logic clk,
	input  logic arst_n,
	fapdl_in_if  item_in,
	fapdl_out_if result_out,
	fapdl_cfg_if cfg,
	output int   reports_due,
	output int   fail_count
);

	typedef struct packed {
		logic signed [fapdl_pkg::DRIVE_W-1:0] drive;
		logic signed [fapdl_pkg::POS_W-1:0]   position;
		logic                                 slow_zone;
		logic signed [fapdl_pkg::TURN_W-1:0]  turns;
	} axis_report_t;

	localparam int     HALF = int'(fapdl_pkg::WRAP_HALF_DEF);
	localparam longint SPAN = longint'(fapdl_pkg::ENCODER_SPAN_DEF);

	// register copies
	logic [fapdl_pkg::LIMIT_W-1:0] enter_lo, exit_lo, exit_hi, enter_hi, travel_lim;
	logic [fapdl_pkg::SPEED_W-1:0] norm_spd, slow_spd;

	// axis state
	logic                                 seeded;
	logic signed [fapdl_pkg::RAW_W-1:0]   prev_raw;
	logic signed [fapdl_pkg::TURN_W-1:0]  turn_cnt;
	logic [fapdl_pkg::POS_W-1:0]          zero_off;
	logic [fapdl_pkg::POS_W-1:0]          axis_pos;
	logic                                 sw_a_q, sw_b_q, slow_q;
	logic signed [fapdl_pkg::DRIVE_W-1:0] drive_cmd;

	axis_report_t due_reports[$];
	axis_report_t seen, owed;
	int fails = 0;

	assign fail_count = fails;

	function automatic void load_register(logic [fapdl_pkg::CFG_IDX_W-1:0] idx,
			logic [fapdl_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			fapdl_pkg::CFG_SLOW_ENTER_LOW:  enter_lo = data;
			fapdl_pkg::CFG_SLOW_EXIT_LOW:   exit_lo = data;
			fapdl_pkg::CFG_SLOW_EXIT_HIGH:  exit_hi = data;
			fapdl_pkg::CFG_SLOW_ENTER_HIGH: enter_hi = data;
			fapdl_pkg::CFG_TRAVEL_LIMIT:    travel_lim = data;
			fapdl_pkg::CFG_NORMAL_SPEED:    norm_spd = data[fapdl_pkg::SPEED_W-1:0];
			fapdl_pkg::CFG_SLOW_SPEED:      slow_spd = data[fapdl_pkg::SPEED_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic axis_report_t advance_axis(logic [fapdl_pkg::MODE_W-1:0] m,
			logic signed [fapdl_pkg::RAW_W-1:0] raw, logic a, logic b, logic up,
			logic down);
		int jump;
		int spd;
		longint posn;
		logic [fapdl_pkg::POS_W-1:0] total;
		axis_report_t r;
		case (fapdl_pkg::mode_t'(m))
			fapdl_pkg::MODE_SAMPLE: begin
				sw_a_q = a;
				sw_b_q = b;
				if (!seeded) begin
					prev_raw = raw;
					seeded = 1'b1;
				end
				jump = int'(raw) - int'(prev_raw);
				if (jump > HALF)
					turn_cnt = turn_cnt - 1;
				else if (jump < -HALF)
					turn_cnt = turn_cnt + 1;
				prev_raw = raw;
				total = fapdl_pkg::POS_W'(longint'(turn_cnt) * SPAN + longint'(raw));
				if (a)
					zero_off = total;
				axis_pos = '0 - (total - zero_off);
			end
			fapdl_pkg::MODE_BUTTON: begin
				posn = longint'($signed(axis_pos));
				// entry test wins over the clear band; neither keeps the flag
				if (posn <= longint'(enter_lo) || posn >= longint'(enter_hi))
					slow_q = 1'b1;
				else if (posn >= longint'(exit_lo) && posn <= longint'(exit_hi))
					slow_q = 1'b0;
				spd = slow_q ? int'(slow_spd) : int'(norm_spd);
				if (spd > int'(fapdl_pkg::SPEED_MAX))
					spd = int'(fapdl_pkg::SPEED_MAX);
				if (sw_a_q)
					drive_cmd = fapdl_pkg::DRIVE_W'(down ? -spd : 0);
				else if (sw_b_q || posn >= longint'(travel_lim))
					drive_cmd = fapdl_pkg::DRIVE_W'(up ? spd : 0);
				else if (up)
					drive_cmd = fapdl_pkg::DRIVE_W'(spd);
				else if (down)
					drive_cmd = fapdl_pkg::DRIVE_W'(-spd);
				else
					drive_cmd = '0;
			end
			fapdl_pkg::MODE_TICK: begin
				if (sw_a_q && drive_cmd > 0)
					drive_cmd = '0;
				if (sw_b_q && drive_cmd < 0)
					drive_cmd = '0;
			end
			default: ;
		endcase
		r.drive     = drive_cmd;
		r.position  = axis_pos;
		r.slow_zone = slow_q;
		r.turns     = turn_cnt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_lo   = fapdl_pkg::SLOW_ENTER_LOW_RST;
			exit_lo    = fapdl_pkg::SLOW_EXIT_LOW_RST;
			exit_hi    = fapdl_pkg::SLOW_EXIT_HIGH_RST;
			enter_hi   = fapdl_pkg::SLOW_ENTER_HIGH_RST;
			travel_lim = fapdl_pkg::TRAVEL_LIMIT_RST;
			norm_spd   = fapdl_pkg::NORMAL_SPEED_RST;
			slow_spd   = fapdl_pkg::SLOW_SPEED_RST;
			seeded     = 1'b0;
			prev_raw   = '0;
			turn_cnt   = '0;
			zero_off   = '0;
			axis_pos   = '0;
			sw_a_q     = 1'b0;
			sw_b_q     = 1'b0;
			slow_q     = 1'b0;
			drive_cmd  = '0;
			due_reports.delete();
			reports_due <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				load_register(cfg.index, cfg.data);
			// retire the outgoing transaction before queueing the incoming one
			if (result_out.valid && result_out.ready) begin
				seen.drive     = result_out.drive;
				seen.position  = result_out.position;
				seen.slow_zone = result_out.slow_zone;
				seen.turns     = result_out.turns;
				if (due_reports.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result with nothing outstanding: drive %0d position %0d",
							$time, seen.drive, seen.position);
				end else begin
					owed = due_reports.pop_front();
					if (seen !== owed) begin
						fails++;
						if (fails <= 10)
							$display(
								"%0t: exp/got drive %0d/%0d pos %0d/%0d slow %0b/%0b turns %0d/%0d",
								$time, owed.drive, seen.drive, owed.position, seen.position,
								owed.slow_zone, seen.slow_zone, owed.turns, seen.turns);
					end
				end
			end
			if (item_in.valid && item_in.ready)
				due_reports.push_back(advance_axis(item_in.mode, item_in.encoder_raw,
					item_in.switch_a, item_in.switch_b, item_in.raise_button,
					item_in.lower_button));
			reports_due <= due_reports.size();
		end
	end

endmodule

@@ sim/fork_axis_position_and_drive_limit_tb.sv @@
`timescale 1ns / 100ps

module fork_axis_position_and_drive_limit_tb;

	localparam logic [fapdl_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

	logic clk;
	logic arst_n;
	logic steady;
	logic heading;
	logic signed [fapdl_pkg::RAW_W-1:0] enc_now;
	int reports_due;
	int fail_count;

	fapdl_in_if  item_in();
	fapdl_out_if result_out();
	fapdl_cfg_if cfg();

	fork_axis_position_and_drive_limit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.result_out (result_out),
		.cfg        (cfg)
	);

	fork_axis_report_check check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_in     (item_in),
		.result_out  (result_out),
		.cfg         (cfg),
		.reports_due (reports_due),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk)
		result_out.ready <= steady || ($urandom_range(99) >= 14);

	task automatic push_item(input logic [fapdl_pkg::MODE_W-1:0] m,
			input logic signed [fapdl_pkg::RAW_W-1:0] raw,
			input logic a, input logic b, input logic up, input logic down);
		while (!steady && $urandom_range(99) < 14) begin
			item_in.valid <= 1'b0;
			@(posedge clk);
		end
		item_in.valid        <= 1'b1;
		item_in.mode         <= m;
		item_in.encoder_raw  <= raw;
		item_in.switch_a     <= a;
		item_in.switch_b     <= b;
		item_in.raise_button <= up;
		item_in.lower_button <= down;
		do @(posedge clk); while (!item_in.ready);
	endtask

	// leaves valid high; the caller drops it after the last write
	task automatic write_reg(input logic [fapdl_pkg::CFG_IDX_W-1:0] idx,
			input logic [fapdl_pkg::CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// wait for every outstanding transaction to come back
	task automatic settle();
		item_in.valid <= 1'b0;
		@(posedge clk);
		while (reports_due != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_limits(input int phase);
		logic [fapdl_pkg::CFG_DATA_W-1:0] el, xl, xh, eh, tl, ns, ss;
		case (phase)
			1: begin
				el = '1; xl = '1; xh = '1; eh = '1; tl = '1; ns = '1; ss = 31'd100;
			end
			2: begin
				el = '0; xl = '0; xh = '0; eh = '0; tl = '0; ns = '0; ss = '0;
			end
			4: begin
				el = fapdl_pkg::CFG_DATA_W'($urandom());
				xl = fapdl_pkg::CFG_DATA_W'($urandom());
				xh = fapdl_pkg::CFG_DATA_W'($urandom());
				eh = fapdl_pkg::CFG_DATA_W'($urandom());
				tl = fapdl_pkg::CFG_DATA_W'($urandom());
				ns = fapdl_pkg::CFG_DATA_W'($urandom());
				ss = fapdl_pkg::CFG_DATA_W'($urandom());
			end
			default: begin
				// ordered band at the scale the encoder walk reaches
				el = fapdl_pkg::CFG_DATA_W'($urandom_range(20000));
				xl = el + fapdl_pkg::CFG_DATA_W'($urandom_range(8000));
				xh = xl + fapdl_pkg::CFG_DATA_W'($urandom_range(40000));
				eh = xh + fapdl_pkg::CFG_DATA_W'($urandom_range(8000));
				tl = fapdl_pkg::CFG_DATA_W'($urandom_range(90000));
				ns = fapdl_pkg::CFG_DATA_W'($urandom_range(127));
				ss = fapdl_pkg::CFG_DATA_W'($urandom_range(100));
			end
		endcase
		write_reg(fapdl_pkg::CFG_SLOW_ENTER_LOW, el);
		write_reg(fapdl_pkg::CFG_SLOW_EXIT_LOW, xl);
		write_reg(fapdl_pkg::CFG_SLOW_EXIT_HIGH, xh);
		write_reg(fapdl_pkg::CFG_SLOW_ENTER_HIGH, eh);
		write_reg(fapdl_pkg::CFG_TRAVEL_LIMIT, tl);
		write_reg(fapdl_pkg::CFG_NORMAL_SPEED, ns);
		write_reg(fapdl_pkg::CFG_SLOW_SPEED, ss);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_item();
		int pick;
		int stride;
		logic [fapdl_pkg::MODE_W-1:0] m;
		logic signed [fapdl_pkg::RAW_W-1:0] raw;
		logic [3:0] flags;
		pick  = $urandom_range(99);
		raw   = fapdl_pkg::RAW_W'($urandom());
		flags = 4'($urandom());
		if (pick < 45) begin
			// encoder walk: steps stay well inside half a turn
			if ($urandom_range(99) < 3)
				heading = !heading;
			stride = $urandom_range(9000);
			if ($urandom_range(99) < 20)
				stride = -(stride / 4);
			enc_now = enc_now + fapdl_pkg::RAW_W'(heading ? stride : -stride);
			push_item(fapdl_pkg::MODE_SAMPLE, enc_now, $urandom_range(99) < 4,
				$urandom_range(99) < 10, flags[0], flags[1]);
		end else if (pick < 80) begin
			push_item(fapdl_pkg::MODE_BUTTON, raw, flags[2], flags[3], flags[0], flags[1]);
		end else if (pick < 95) begin
			push_item(fapdl_pkg::MODE_TICK, raw, flags[2], flags[3], flags[0], flags[1]);
		end else begin
			m = fapdl_pkg::MODE_W'($urandom_range(3));
			if (m == fapdl_pkg::MODE_SAMPLE)
				enc_now = raw;
			push_item(m, raw, flags[2], flags[3], flags[0], flags[1]);
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		steady                = 1'b0;
		heading               = 1'b0;
		enc_now               = '0;
		item_in.valid         = 1'b0;
		item_in.mode          = fapdl_pkg::MODE_SAMPLE;
		item_in.encoder_raw   = '0;
		item_in.switch_a      = 1'b0;
		item_in.switch_b      = 1'b0;
		item_in.raise_button  = 1'b0;
		item_in.lower_button  = 1'b0;
		cfg.valid             = 1'b0;
		cfg.index             = fapdl_pkg::CFG_SLOW_ENTER_LOW;
		cfg.data              = '0;
		result_out.ready      = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// buttons and tick before any sample
		push_item(fapdl_pkg::MODE_BUTTON, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_item(fapdl_pkg::MODE_TICK, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
		// first sample seeds, then wrap both ways at the extremes
		push_item(fapdl_pkg::MODE_SAMPLE, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_SAMPLE, 16'sd32767, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_SAMPLE, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0);
		// exactly half a turn either way: no wrap
		push_item(fapdl_pkg::MODE_SAMPLE, -16'sd16384, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_SAMPLE, -16'sd32768, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_SAMPLE, 16'sd1, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_SAMPLE, 16'sd0, 1'b1, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_SAMPLE, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
		// both buttons with no switch: raise wins
		push_item(fapdl_pkg::MODE_BUTTON, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b1);
		// into the clear band
		push_item(fapdl_pkg::MODE_SAMPLE, -16'sd12000, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_BUTTON, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b1);
		// switch B cuts negative drive
		push_item(fapdl_pkg::MODE_SAMPLE, -16'sd12000, 1'b0, 1'b1, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_TICK, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_BUTTON, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b1);
		push_item(fapdl_pkg::MODE_BUTTON, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b0);
		// switch A zeroes position and cuts positive drive
		push_item(fapdl_pkg::MODE_SAMPLE, -16'sd12000, 1'b1, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_TICK, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
		push_item(fapdl_pkg::MODE_BUTTON, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b1);
		push_item(fapdl_pkg::MODE_BUTTON, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b0);
		push_item(MODE_SPARE, 16'sd32767, 1'b1, 1'b1, 1'b1, 1'b1);
		push_item(fapdl_pkg::MODE_SAMPLE, 16'sd0, 1'b0, 1'b0, 1'b0, 1'b0);
		enc_now = '0;

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				settle();
				program_limits(phase);
			end
			steady <= (phase == 3);
			repeat (240) random_item();
		end
		settle();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
